// ----- hdl/tpc_pkg.sv -----
// ----------------------------------------------------------------------------
// tpc_pkg: shared types, constants and functions of the centroid unit
// Field widths, command and register codes, the CORDIC angle table in turns
// and the 32-bit saturation of wide centroid values.
// ----------------------------------------------------------------------------
`default_nettype none
package tpc_pkg;

  localparam int MAX_SITES_DEF = 4096;
  localparam int SITE_W        = 12;
  localparam int Z_W           = 16;
  localparam int C_W           = 32;
  localparam int EXT_W         = 16;
  localparam int ANG_W         = 32;
  localparam int CORDIC_STEPS  = 31;
  localparam int VAL_W         = 52;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_W         = 32;
  localparam int IN_TDATA_W    = 176;
  localparam int IN_TUSER_W    = 2;
  localparam int OUT_TDATA_W   = 32;
  localparam int OUT_TUSER_W   = 2;

  localparam logic signed [Z_W-1:0] THRESH_RST = -16'sd33;
  localparam logic signed [Z_W-1:0] SPIN_RST   = 16'sh7FFF;
  localparam logic [EXT_W-1:0]      EXTENT_RST = 16'd64;
  localparam logic signed [C_W-1:0] COEF_A_RST = 32'sd65536;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_SET   = 2'd1,
    CMD_FULL  = 2'd2,
    CMD_TRIAL = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESHOLD = 3'd0,
    REG_SELECT_Y  = 3'd1,
    REG_WRAP_X    = 3'd2,
    REG_WRAP_Y    = 3'd3,
    REG_EXTENT_A  = 3'd4,
    REG_EXTENT_B  = 3'd5,
    REG_COEF_A    = 3'd6,
    REG_COEF_B    = 3'd7
  } reg_idx_t;

  function automatic logic [ANG_W-1:0] atan_turn(input logic [4:0] i);
    logic [ANG_W-1:0] t;
    case (i)
      5'd0:  t = 32'h20000000;
      5'd1:  t = 32'h12E4051E;
      5'd2:  t = 32'h09FB385B;
      5'd3:  t = 32'h051111D4;
      5'd4:  t = 32'h028B0D43;
      5'd5:  t = 32'h0145D7E1;
      5'd6:  t = 32'h00A2F61E;
      5'd7:  t = 32'h00517C55;
      5'd8:  t = 32'h0028BE53;
      5'd9:  t = 32'h00145F2F;
      5'd10: t = 32'h000A2F98;
      5'd11: t = 32'h000517CC;
      5'd12: t = 32'h00028BE6;
      5'd13: t = 32'h000145F3;
      5'd14: t = 32'h0000A2FA;
      5'd15: t = 32'h0000517D;
      5'd16: t = 32'h000028BE;
      5'd17: t = 32'h0000145F;
      5'd18: t = 32'h00000A30;
      5'd19: t = 32'h00000518;
      5'd20: t = 32'h0000028C;
      5'd21: t = 32'h00000146;
      5'd22: t = 32'h000000A3;
      5'd23: t = 32'h00000051;
      5'd24: t = 32'h00000029;
      5'd25: t = 32'h00000014;
      5'd26: t = 32'h0000000A;
      5'd27: t = 32'h00000005;
      5'd28: t = 32'h00000003;
      5'd29: t = 32'h00000001;
      5'd30: t = 32'h00000001;
      default: t = '0;
    endcase
    return t;
  endfunction

  function automatic logic signed [C_W-1:0] sat_val(input logic signed [VAL_W-1:0] v);
    logic signed [C_W-1:0] r;
    if (v > VAL_W'(32'sh7FFFFFFF)) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -VAL_W'(33'sh080000000)) begin
      r = 32'sh80000000;
    end else begin
      r = v[C_W-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- hdl/tpc_ram.sv -----
// ----------------------------------------------------------------------------
// tpc_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module tpc_ram #(
  parameter int W = 8,
  parameter int D = 16,
  localparam int AW = (D > 1) ? $clog2(D) : 1
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [W-1:0]  wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [W-1:0]  rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- hdl/tpc_axis.sv -----
// ----------------------------------------------------------------------------
// tpc_axis: one axis coordinate from summed remapped positions
// Periodic axis: CORDIC vectoring, one iteration per cycle, then angle times
// extent. Open axis: restoring divide of the sum by the count, one bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module tpc_axis #(
  parameter int SUM_W = 45,
  parameter int CNT_W = 13
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  input  wire logic                             wrap,
  input  wire logic signed [SUM_W-1:0]          along,
  input  wire logic signed [SUM_W-1:0]          depth,
  input  wire logic [CNT_W-1:0]                 count,
  input  wire logic [tpc_pkg::EXT_W-1:0]        extent,
  output logic                                  done,
  output logic signed [tpc_pkg::C_W-1:0]        coord
);

  localparam int XW   = SUM_W + 2;
  localparam int IT_W = $clog2(SUM_W + 1);
  localparam int PW   = tpc_pkg::ANG_W + tpc_pkg::EXT_W;

  typedef enum logic [2:0] {A_IDLE, A_CORD, A_SCALE, A_FIN_C, A_DIV, A_FIN_D} ax_state_t;

  ax_state_t                        st_r;
  logic signed [XW-1:0]             x_r, y_r;
  logic [tpc_pkg::ANG_W-1:0]        ang_r;
  logic [IT_W-1:0]                  it_r;
  logic [PW-1:0]                    prod_r;
  logic [tpc_pkg::EXT_W-1:0]        ext_r;
  logic [SUM_W-1:0]                 num_r;
  logic [CNT_W-1:0]                 rem_r, den_r;
  logic                             neg_r;
  logic signed [XW-1:0]             dx, dy;
  logic [CNT_W:0]                   trial;
  logic [tpc_pkg::ANG_W-1:0]        tab;

  assign dx    = y_r >>> it_r;
  assign dy    = x_r >>> it_r;
  assign tab   = tpc_pkg::atan_turn(it_r[4:0]);
  assign trial = {rem_r, num_r[SUM_W-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= A_IDLE;
      done <= 1'b0;
    end else begin
      case (st_r)
        A_IDLE: begin
          done <= start && (wrap ? (along == '0 && depth == '0) : (count == '0));
          if (start) begin
            ext_r <= extent;
            it_r  <= '0;
            if (wrap) begin
              if (along == '0 && depth == '0) begin
                coord <= '0;
              end else begin
                if (along < 0) begin
                  x_r   <= -XW'(along);
                  y_r   <= -XW'(depth);
                  ang_r <= 32'h80000000;
                end else begin
                  x_r   <= XW'(along);
                  y_r   <= XW'(depth);
                  ang_r <= '0;
                end
                st_r <= A_CORD;
              end
            end else begin
              if (count == '0) begin
                coord <= '0;
              end else begin
                num_r <= (along < 0) ? SUM_W'(-along) : SUM_W'(along);
                neg_r <= along < 0;
                rem_r <= '0;
                den_r <= count;
                st_r  <= A_DIV;
              end
            end
          end
        end
        A_CORD: begin
          if (y_r > 0) begin
            x_r   <= x_r + dx;
            y_r   <= y_r - dy;
            ang_r <= ang_r + tab;
          end else begin
            x_r   <= x_r - dx;
            y_r   <= y_r + dy;
            ang_r <= ang_r - tab;
          end
          it_r <= it_r + 1'b1;
          if (it_r == IT_W'(tpc_pkg::CORDIC_STEPS - 1)) begin
            st_r <= A_SCALE;
          end
        end
        A_SCALE: begin
          prod_r <= PW'(ang_r) * PW'(ext_r);
          st_r   <= A_FIN_C;
        end
        A_FIN_C: begin
          coord <= prod_r[PW-1] ? 32'sh7FFFFFFF : $signed(prod_r[PW-1:16]);
          done  <= 1'b1;
          st_r  <= A_IDLE;
        end
        A_DIV: begin
          if (trial >= {1'b0, den_r}) begin
            rem_r <= CNT_W'(trial - {1'b0, den_r});
            num_r <= {num_r[SUM_W-2:0], 1'b1};
          end else begin
            rem_r <= trial[CNT_W-1:0];
            num_r <= {num_r[SUM_W-2:0], 1'b0};
          end
          it_r <= it_r + 1'b1;
          if (it_r == IT_W'(SUM_W - 1)) begin
            st_r <= A_FIN_D;
          end
        end
        A_FIN_D: begin
          if (neg_r) begin
            coord <= (num_r > SUM_W'(33'h080000000)) ? 32'sh80000000
                                                     : -$signed(num_r[31:0]);
          end else begin
            coord <= (num_r > SUM_W'(32'h7FFFFFFF)) ? 32'sh7FFFFFFF
                                                    : $signed(num_r[31:0]);
          end
          done <= 1'b1;
          st_r <= A_IDLE;
        end
        default: st_r <= A_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- hdl/thresholded_periodic_centroid_unit.sv -----
// ----------------------------------------------------------------------------
// thresholded_periodic_centroid_unit: centroid of core sites of a spin lattice
// Site store in two RAMs, sweep accumulator, axis unit and matrix row product.
// ----------------------------------------------------------------------------
// After reset the spin store is set to the non-core value by a clearing pass
// over all MAX_SITES sites, during which no beat is taken; configuration writes
// are accepted at any time. One beat is processed at a time. Load and set go
// straight to the result. A full centroid sweeps the site RAMs at one site per
// cycle, then runs the axis unit for each axis: CORDIC for a periodic axis (31
// iterations) or a restoring divide for an open axis (one quotient bit per cycle),
// then the products and sums. A crossing trial uses the same sweep and runs the
// axis stage twice; a trial without crossing, or with a site out of range, goes
// straight to the result.
`default_nettype none
module thresholded_periodic_centroid_unit #(
  parameter int MAX_SITES = tpc_pkg::MAX_SITES_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // site, spin_z, trial_z, remap_a_along, remap_a_depth, remap_b_along,
  // remap_b_depth, zero fill
  input  wire logic [tpc_pkg::IN_TDATA_W-1:0]      in_tdata,
  // cmd
  input  wire logic [tpc_pkg::IN_TUSER_W-1:0]      in_tuser,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // coordinate
  output logic [tpc_pkg::OUT_TDATA_W-1:0]          out_tdata,
  // crossed, no_core
  output logic [tpc_pkg::OUT_TUSER_W-1:0]          out_tuser,
  input  wire logic                                cfg_we,
  input  wire logic [tpc_pkg::CFG_IDX_W-1:0]       cfg_addr,
  input  wire logic [tpc_pkg::CFG_W-1:0]           cfg_data
);

  localparam int AW    = (MAX_SITES > 1) ? $clog2(MAX_SITES) : 1;
  localparam int CNT_W = AW + 1;
  localparam int SUM_W = tpc_pkg::C_W + AW + 1;
  localparam int SW    = tpc_pkg::SITE_W + AW;
  localparam int TW    = 4 * tpc_pkg::C_W;
  localparam int C_W   = tpc_pkg::C_W;
  localparam int VAL_W = tpc_pkg::VAL_W;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_SWEEP, S_AXA_GO, S_AXA_WAIT, S_AXB_GO, S_AXB_WAIT,
    S_MUL_A, S_MUL_B, S_SUM, S_DONE
  } state_t;

  // Configuration registers
  logic signed [tpc_pkg::Z_W-1:0] thr_r;
  logic                           sel_y_r, wrap_x_r, wrap_y_r;
  logic [tpc_pkg::EXT_W-1:0]      ext_a_r, ext_b_r;
  logic signed [C_W-1:0]          coef_a_r, coef_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r    <= tpc_pkg::THRESH_RST;
      sel_y_r  <= 1'b0;
      wrap_x_r <= 1'b1;
      wrap_y_r <= 1'b1;
      ext_a_r  <= tpc_pkg::EXTENT_RST;
      ext_b_r  <= tpc_pkg::EXTENT_RST;
      coef_a_r <= tpc_pkg::COEF_A_RST;
      coef_b_r <= '0;
    end else if (cfg_we) begin
      case (tpc_pkg::reg_idx_t'(cfg_addr))
        tpc_pkg::REG_THRESHOLD: thr_r    <= $signed(cfg_data[15:0]);
        tpc_pkg::REG_SELECT_Y:  sel_y_r  <= cfg_data[0];
        tpc_pkg::REG_WRAP_X:    wrap_x_r <= cfg_data[0];
        tpc_pkg::REG_WRAP_Y:    wrap_y_r <= cfg_data[0];
        tpc_pkg::REG_EXTENT_A:  ext_a_r  <= cfg_data[15:0];
        tpc_pkg::REG_EXTENT_B:  ext_b_r  <= cfg_data[15:0];
        tpc_pkg::REG_COEF_A:    coef_a_r <= $signed(cfg_data);
        tpc_pkg::REG_COEF_B:    coef_b_r <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // Input fields
  tpc_pkg::cmd_t                   in_cmd;
  logic [tpc_pkg::SITE_W-1:0]      in_site;
  logic signed [tpc_pkg::Z_W-1:0]  in_spin, in_trial;
  logic [TW-1:0]                   in_tube;
  logic [SW-1:0]                   site_wide;
  logic                            site_ok;
  logic                            accept;
  logic                            in_cross;

  assign in_cmd    = tpc_pkg::cmd_t'(in_tuser[1:0]);
  assign in_site   = in_tdata[11:0];
  assign in_spin   = $signed(in_tdata[27:12]);
  assign in_trial  = $signed(in_tdata[43:28]);
  assign in_tube   = in_tdata[171:44];
  assign site_wide = SW'(in_site);
  assign site_ok   = site_wide < SW'(MAX_SITES);
  assign accept    = in_tvalid && in_tready;
  assign in_cross  = (in_spin <= thr_r) != (in_trial <= thr_r);

  // Control and datapath registers
  state_t                 st_r;
  tpc_pkg::cmd_t          cmd_r;
  logic [AW:0]            sw_r;
  logic                   d_vld_r;
  logic [AW-1:0]          d_idx_r, site_r;
  logic                   zi_r, zt_r, set_r;
  logic [CNT_W-1:0]       cnt_r;
  logic signed [SUM_W-1:0] acc0_r, acc1_r, acc2_r, acc3_r;
  logic signed [C_W-1:0]  st0_r, st1_r, st2_r, st3_r;
  logic signed [C_W-1:0]  c0_r, c1_r, cached_r;
  logic signed [63:0]     prod_r;
  logic signed [47:0]     part_r;
  logic signed [VAL_W-1:0] vi_r;
  logic                   out_valid_r, crossed_r, nocore_r;
  logic signed [C_W-1:0]  res_r;
  logic [C_W-1:0]         out_data_r;
  logic [1:0]             out_user_r;

  // Site RAMs
  logic                   spin_we, tube_we;
  logic [AW-1:0]          spin_waddr;
  logic [tpc_pkg::Z_W-1:0] spin_wdata, spin_q;
  logic [TW-1:0]          tube_q;
  logic                   issue;

  assign issue      = sw_r < (AW+1)'(MAX_SITES);
  assign spin_we    = (st_r == S_CLEAR) ||
                      (accept && site_ok &&
                       (in_cmd == tpc_pkg::CMD_LOAD || in_cmd == tpc_pkg::CMD_SET));
  assign tube_we    = accept && site_ok && in_cmd == tpc_pkg::CMD_LOAD;
  assign spin_waddr = (st_r == S_CLEAR) ? sw_r[AW-1:0] : site_wide[AW-1:0];
  assign spin_wdata = (st_r == S_CLEAR) ? tpc_pkg::SPIN_RST : in_spin;

  tpc_ram #(.W(tpc_pkg::Z_W), .D(MAX_SITES)) u_spin_ram (
    .clk   (clk),
    .we    (spin_we),
    .waddr (spin_waddr),
    .wdata (spin_wdata),
    .raddr (sw_r[AW-1:0]),
    .rdata (spin_q)
  );

  tpc_ram #(.W(TW), .D(MAX_SITES)) u_tube_ram (
    .clk   (clk),
    .we    (tube_we),
    .waddr (site_wide[AW-1:0]),
    .wdata (in_tube),
    .raddr (sw_r[AW-1:0]),
    .rdata (tube_q)
  );

  // Core test on the read data of the sweep
  logic is_trial, core_hit, inc;
  assign is_trial = cmd_r == tpc_pkg::CMD_TRIAL;
  assign core_hit = d_vld_r && ($signed(spin_q) <= thr_r) &&
                    !(is_trial && d_idx_r == site_r);
  assign inc      = is_trial && (set_r ? zt_r : zi_r);

  // Point set handed to the axis unit
  logic signed [SUM_W-1:0] set0, set1, set2, set3;
  logic [CNT_W-1:0]        set_cnt;
  assign set0    = acc0_r + (inc ? SUM_W'(st0_r) : '0);
  assign set1    = acc1_r + (inc ? SUM_W'(st1_r) : '0);
  assign set2    = acc2_r + (inc ? SUM_W'(st2_r) : '0);
  assign set3    = acc3_r + (inc ? SUM_W'(st3_r) : '0);
  assign set_cnt = cnt_r + CNT_W'(inc);

  logic                    ax_start, ax_b, ax_done;
  logic signed [C_W-1:0]   ax_coord;
  assign ax_start = (st_r == S_AXA_GO) || (st_r == S_AXB_GO);
  assign ax_b     = st_r == S_AXB_GO;

  tpc_axis #(.SUM_W(SUM_W), .CNT_W(CNT_W)) u_axis (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (ax_start),
    .wrap   (ax_b ? wrap_y_r : wrap_x_r),
    .along  (ax_b ? set2 : set0),
    .depth  (ax_b ? set3 : set1),
    .count  (set_cnt),
    .extent (ax_b ? ext_b_r : ext_a_r),
    .done   (ax_done),
    .coord  (ax_coord)
  );

  logic signed [VAL_W-1:0] val;
  assign val = VAL_W'(part_r) + VAL_W'($signed(prod_r[63:16]));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_CLEAR;
      sw_r        <= '0;
      d_vld_r     <= 1'b0;
      out_valid_r <= 1'b0;
      cached_r    <= '0;
    end else begin
      if (out_valid_r && out_tready && st_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      d_vld_r <= (st_r == S_SWEEP) && issue;
      case (st_r)
        S_CLEAR: begin
          sw_r <= sw_r + 1'b1;
          if (sw_r == (AW+1)'(MAX_SITES - 1)) begin
            st_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            cmd_r     <= in_cmd;
            site_r    <= site_wide[AW-1:0];
            zi_r      <= in_spin <= thr_r;
            zt_r      <= in_trial <= thr_r;
            set_r     <= 1'b0;
            res_r     <= (in_cmd == tpc_pkg::CMD_TRIAL) ? cached_r : '0;
            crossed_r <= (in_cmd == tpc_pkg::CMD_TRIAL) && in_cross;
            nocore_r  <= 1'b0;
            sw_r      <= '0;
            cnt_r     <= '0;
            acc0_r    <= '0;
            acc1_r    <= '0;
            acc2_r    <= '0;
            acc3_r    <= '0;
            if (in_cmd == tpc_pkg::CMD_FULL ||
                (in_cmd == tpc_pkg::CMD_TRIAL && in_cross && site_ok)) begin
              st_r <= S_SWEEP;
            end else begin
              st_r <= S_DONE;
            end
          end
        end
        S_SWEEP: begin
          if (issue) begin
            sw_r    <= sw_r + 1'b1;
            d_idx_r <= sw_r[AW-1:0];
          end
          if (core_hit) begin
            acc0_r <= acc0_r + SUM_W'($signed(tube_q[31:0]));
            acc1_r <= acc1_r + SUM_W'($signed(tube_q[63:32]));
            acc2_r <= acc2_r + SUM_W'($signed(tube_q[95:64]));
            acc3_r <= acc3_r + SUM_W'($signed(tube_q[127:96]));
            cnt_r  <= cnt_r + 1'b1;
          end
          if (d_vld_r && d_idx_r == site_r) begin
            st0_r <= $signed(tube_q[31:0]);
            st1_r <= $signed(tube_q[63:32]);
            st2_r <= $signed(tube_q[95:64]);
            st3_r <= $signed(tube_q[127:96]);
          end
          if (!issue && !d_vld_r) begin
            st_r <= S_AXA_GO;
          end
        end
        S_AXA_GO:   st_r <= S_AXA_WAIT;
        S_AXA_WAIT: begin
          if (ax_done) begin
            c0_r <= ax_coord;
            st_r <= S_AXB_GO;
          end
        end
        S_AXB_GO:   st_r <= S_AXB_WAIT;
        S_AXB_WAIT: begin
          if (ax_done) begin
            c1_r <= ax_coord;
            st_r <= S_MUL_A;
          end
        end
        S_MUL_A: begin
          prod_r <= 64'(coef_a_r) * 64'(c0_r);
          st_r   <= S_MUL_B;
        end
        S_MUL_B: begin
          part_r <= $signed(prod_r[63:16]);
          prod_r <= 64'(coef_b_r) * 64'(c1_r);
          st_r   <= S_SUM;
        end
        S_SUM: begin
          if (!is_trial) begin
            res_r    <= tpc_pkg::sat_val(val);
            cached_r <= tpc_pkg::sat_val(val);
            nocore_r <= set_cnt == '0;
            st_r     <= S_DONE;
          end else if (!set_r) begin
            vi_r  <= val;
            set_r <= 1'b1;
            st_r  <= S_AXA_GO;
          end else begin
            res_r    <= tpc_pkg::sat_val(VAL_W'(cached_r) + val - vi_r);
            nocore_r <= set_cnt == '0;
            st_r     <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_data_r  <= res_r;
            out_user_r  <= {nocore_r, crossed_r};
            st_r        <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign in_tready  = st_r == S_IDLE;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  logic unused_sel;
  assign unused_sel = sel_y_r;

  // A beat starts work that blocks the input in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken on two consecutive cycles");

  // A result beat holds steady until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat changed while stalled");

  // No beat is taken while the spin store is being cleared.
  a_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == S_CLEAR |-> !in_tready)
    else $error("input ready during the clearing pass");

endmodule
`default_nettype wire
